[rtl/grw_pkg.sv]
// Shared types and constants for the grid ray cell walker.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package grw_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned MAP_SIDE_DEF  = 64;
  localparam int unsigned CELL_BITS_DEF = 8;

  // Saturation limit for unit steps, side lengths and the distance.
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

  // The unit step is 2^30 / |dir|, so the quotient has 31 bits.
  localparam int unsigned DIV_BITS = 31;

  // Request operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Configuration register indexes and reset values.
  localparam logic       CFG_MAP_WIDTH  = 1'b0;
  localparam logic       CFG_MAP_HEIGHT = 1'b1;
  localparam logic [6:0] MAP_DIM_RESET  = 7'd10;

  typedef struct packed {
    logic               operation;
    logic        [5:0]  cell_x;
    logic        [5:0]  cell_y;
    logic        [7:0]  cell_value;
    logic        [21:0] start_x;
    logic        [21:0] start_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } grw_req_t;

  typedef struct packed {
    logic signed [7:0]  hit_x;
    logic signed [7:0]  hit_y;
    logic        [7:0]  hit_value;
    logic               outside_map;
    logic        [23:0] distance;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
  } grw_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_SIDE_MX,
    ST_SIDE_MY,
    ST_SIDE_WY,
    ST_STEP,
    ST_CHECK,
    ST_PT_MX,
    ST_PT_MY,
    ST_PT_WY,
    ST_DONE
  } grw_state_e;

  typedef enum logic [1:0] {
    MUL_SIDE_X,
    MUL_SIDE_Y,
    MUL_PT_X,
    MUL_PT_Y
  } grw_mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         mem_wr;
    logic         load;
    logic         div_step;
    logic         div_axis;
    logic         div_first;
    logic         div_last;
    logic         mul_en;
    grw_mul_sel_e mul_sel;
    logic         side_wr_x;
    logic         side_wr_y;
    logic         step;
    logic         finish;
    logic         pt_wr_x;
    logic         pt_wr_y;
  } grw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic on_map;
    logic cell_nz;
  } grw_sts_t;

endpackage

`default_nettype wire

[rtl/grw_ctrl.sv]
// Controller state machine of the grid ray cell walker.
// Depends on grw_pkg; drives grw_dpath through command and status structs.
`default_nettype none

module grw_ctrl
  import grw_pkg::*;
#(
  parameter int unsigned MAP_SIDE = MAP_SIDE_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire logic     operation_i,
  input  grw_sts_t      sts_i,
  output grw_cmd_t      cmd_o,
  output logic          busy,
  output logic          result_valid_o
);

  localparam int unsigned STEP_LIMIT = 2 * MAP_SIDE + 2;
  localparam int unsigned SCW        = $clog2(STEP_LIMIT + 1);
  localparam int unsigned DCW        = $clog2(DIV_BITS);

  grw_state_e       state_q, state_d;
  logic [DCW-1:0]   div_cnt_q, div_cnt_d;
  logic [SCW-1:0]   steps_q, steps_d;
  logic             stop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
      steps_q   <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      steps_q   <= steps_d;
    end
  end

  assign stop = !sts_i.on_map || sts_i.cell_nz || (steps_q == SCW'(STEP_LIMIT));

  always_comb begin
    state_d        = state_q;
    div_cnt_d      = div_cnt_q;
    steps_d        = steps_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_SIDE_X;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    cmd_o.div_first = (div_cnt_q == '0);
    cmd_o.div_last  = (div_cnt_q == DCW'(DIV_BITS - 1));
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation_i == OP_WRITE) begin
            cmd_o.mem_wr = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            div_cnt_d  = '0;
            steps_d    = '0;
            state_d    = ST_DIV_X;
          end
        end
      end
      ST_DIV_X, ST_DIV_Y: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_axis = (state_q == ST_DIV_Y);
        if (cmd_o.div_last) begin
          div_cnt_d = '0;
          state_d   = (state_q == ST_DIV_X) ? ST_DIV_Y : ST_SIDE_MX;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      ST_SIDE_MX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SIDE_X;
        state_d       = ST_SIDE_MY;
      end
      ST_SIDE_MY: begin
        cmd_o.side_wr_x = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_SIDE_Y;
        state_d         = ST_SIDE_WY;
      end
      ST_SIDE_WY: begin
        cmd_o.side_wr_y = 1'b1;
        state_d         = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        steps_d    = steps_q + 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (stop) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_PT_MX;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_PT_MX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_PT_X;
        state_d       = ST_PT_MY;
      end
      ST_PT_MY: begin
        cmd_o.pt_wr_x = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_PT_Y;
        state_d       = ST_PT_WY;
      end
      ST_PT_WY: begin
        cmd_o.pt_wr_y = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        result_valid_o = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/grw_dpath.sv]
// Datapath of the grid ray cell walker: map memory, divider, multiplier, DDA registers.
// Depends on grw_pkg; commanded by grw_ctrl.
`default_nettype none

module grw_dpath
  import grw_pkg::*;
#(
  parameter int unsigned MAP_SIDE  = MAP_SIDE_DEF,
  parameter int unsigned CELL_BITS = CELL_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  grw_req_t        req_i,
  input  grw_cmd_t        cmd_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [6:0] cfg_wdata_i,
  output grw_sts_t        sts_o,
  output grw_rsp_t        result_o
);

  localparam int unsigned DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [CELL_BITS-1:0] mem_q [DEPTH];
  logic [CELL_BITS-1:0] rd_data_q;

  logic [6:0] map_w_q, map_h_q, w_eff, h_eff;

  logic        [21:0] sx_q, sy_q;
  logic signed [15:0] dx_q, dy_q;
  logic        [15:0] rem_q, rem_d;
  logic        [30:0] quo_q, quo_d;
  logic        [23:0] ux_q, uy_q, lx_q, ly_q, dist_q;
  logic signed [7:0]  cx_q, cy_q, nx, ny;
  logic signed [42:0] prod_q;
  logic signed [23:0] px_q, py_q;
  logic        [7:0]  value_q;
  logic               outside_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= MAP_DIM_RESET;
      map_h_q <= MAP_DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MAP_WIDTH) begin
        map_w_q <= cfg_wdata_i;
      end else begin
        map_h_q <= cfg_wdata_i;
      end
    end
  end

  assign w_eff = (int'(map_w_q) > MAP_SIDE) ? 7'(MAP_SIDE) : map_w_q;
  assign h_eff = (int'(map_h_q) > MAP_SIDE) ? 7'(MAP_SIDE) : map_h_q;

  // Map memory: one write port, one registered read port.
  logic [15:0] wr_full, rd_full;
  logic        wr_in_range;

  assign wr_full     = 16'(req_i.cell_y) * 16'(MAP_SIDE) + 16'(req_i.cell_x);
  assign wr_in_range = (int'(req_i.cell_x) < MAP_SIDE) && (int'(req_i.cell_y) < MAP_SIDE);
  assign rd_full     = 16'($unsigned(ny)) * 16'(MAP_SIDE) + 16'($unsigned(nx));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && wr_in_range) begin
      mem_q[wr_full[AW-1:0]] <= CELL_BITS'(req_i.cell_value);
    end
    if (cmd_i.step) begin
      rd_data_q <= mem_q[rd_full[AW-1:0]];
    end
  end

  // Restoring divider for 2^30 / |dir|, one quotient bit a cycle.
  logic signed [15:0] div_d;
  logic        [15:0] div_abs;
  logic        [16:0] trial;
  logic               qbit;
  logic        [23:0] unit_sat;

  assign div_d   = cmd_i.div_axis ? dy_q : dx_q;
  assign div_abs = div_d[15] ? 16'(-div_d) : div_d;
  assign trial   = {rem_q, cmd_i.div_first};
  assign qbit    = (trial >= {1'b0, div_abs});
  assign rem_d   = qbit ? 16'(trial - {1'b0, div_abs}) : trial[15:0];
  assign quo_d   = {quo_q[29:0], qbit};
  assign unit_sat = (quo_d > 31'(DIST_MAX)) ? DIST_MAX : quo_d[23:0];

  // Shared multiplier operands.
  logic signed [17:0] mul_a;
  logic signed [24:0] mul_b;
  logic        [16:0] fx, fy;

  assign fx = dx_q[15] ? {1'b0, sx_q[15:0]} : 17'h10000 - {1'b0, sx_q[15:0]};
  assign fy = dy_q[15] ? {1'b0, sy_q[15:0]} : 17'h10000 - {1'b0, sy_q[15:0]};

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SIDE_X: begin
        mul_a = {1'b0, fx};
        mul_b = {1'b0, ux_q};
      end
      MUL_SIDE_Y: begin
        mul_a = {1'b0, fy};
        mul_b = {1'b0, uy_q};
      end
      MUL_PT_X: begin
        mul_a = 18'(dx_q);
        mul_b = {1'b0, dist_q};
      end
      MUL_PT_Y: begin
        mul_a = 18'(dy_q);
        mul_b = {1'b0, dist_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Side length from the product, and hit point from the product.
  logic [23:0]        side_v;
  logic signed [29:0] pt_sum;
  logic signed [23:0] pt_sat;
  logic [21:0]        pt_start;

  assign side_v   = prod_q[40] ? DIST_MAX : prod_q[39:16];
  assign pt_start = cmd_i.pt_wr_y ? sy_q : sx_q;
  assign pt_sum   = $signed({8'd0, pt_start}) + 30'($signed(prod_q[42:14]));
  always_comb begin
    if (pt_sum > 30'sd8388607) begin
      pt_sat = 24'sh7FFFFF;
    end else if (pt_sum < -30'sd8388608) begin
      pt_sat = 24'sh800000;
    end else begin
      pt_sat = pt_sum[23:0];
    end
  end

  // DDA step: choose the axis, move the cell and grow that side length.
  logic        take_x;
  logic [24:0] lx_sum, ly_sum;

  assign take_x = (lx_q < ly_q) || ((dy_q == '0) && (dx_q != '0));
  assign lx_sum = {1'b0, lx_q} + {1'b0, ux_q};
  assign ly_sum = {1'b0, ly_q} + {1'b0, uy_q};

  always_comb begin
    nx = cx_q;
    ny = cy_q;
    if (take_x) begin
      if (dx_q[15]) begin
        nx = cx_q - 8'sd1;
      end else if (dx_q != '0) begin
        nx = cx_q + 8'sd1;
      end
    end else begin
      if (dy_q[15]) begin
        ny = cy_q - 8'sd1;
      end else if (dy_q != '0) begin
        ny = cy_q + 8'sd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q  <= req_i.start_x;
      sy_q  <= req_i.start_y;
      dx_q  <= req_i.dir_x;
      dy_q  <= req_i.dir_y;
      cx_q  <= 8'(req_i.start_x[21:16]);
      cy_q  <= 8'(req_i.start_y[21:16]);
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (cmd_i.div_last) begin
        rem_q <= '0;
        quo_q <= '0;
        if (cmd_i.div_axis) begin
          uy_q <= unit_sat;
        end else begin
          ux_q <= unit_sat;
        end
      end else begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.side_wr_x) begin
      lx_q <= (dx_q == '0) ? DIST_MAX : side_v;
    end
    if (cmd_i.side_wr_y) begin
      ly_q <= (dy_q == '0) ? DIST_MAX : side_v;
    end
    if (cmd_i.step) begin
      cx_q <= nx;
      cy_q <= ny;
      if (take_x) begin
        dist_q <= lx_q;
        lx_q   <= lx_sum[24] ? DIST_MAX : lx_sum[23:0];
      end else begin
        dist_q <= ly_q;
        ly_q   <= ly_sum[24] ? DIST_MAX : ly_sum[23:0];
      end
    end
    if (cmd_i.finish) begin
      outside_q <= !(sts_o.on_map && sts_o.cell_nz);
      value_q   <= (sts_o.on_map && sts_o.cell_nz) ? 8'(rd_data_q) : 8'd0;
    end
    if (cmd_i.pt_wr_x) begin
      px_q <= pt_sat;
    end
    if (cmd_i.pt_wr_y) begin
      py_q <= pt_sat;
    end
  end

  assign sts_o.on_map  = !cx_q[7] && !cy_q[7] && (cx_q[6:0] < w_eff) && (cy_q[6:0] < h_eff);
  assign sts_o.cell_nz = (rd_data_q != '0);

  assign result_o.hit_x       = cx_q;
  assign result_o.hit_y       = cy_q;
  assign result_o.hit_value   = value_q;
  assign result_o.outside_map = outside_q;
  assign result_o.distance    = dist_q;
  assign result_o.point_x     = px_q;
  assign result_o.point_y     = py_q;

endmodule

`default_nettype wire

[rtl/grid_ray_cell_walker_core.sv]
// Grid ray cell walker, top level. A write request stores one map cell in the
// accepting cycle and gives no result. A cast request runs two serial unit-step
// divisions, then the side lengths, then a step plus registered map read for
// each cell crossed, then the hit point, and ends with the result strobe. The
// next request is taken once busy falls; the receiver cannot stall. Reset clears
// control and configuration (both dimensions to 10) but leaves the map contents
// undefined.
`default_nettype none

module grid_ray_cell_walker_core
  import grw_pkg::*;
#(
  parameter int unsigned MAP_SIDE  = MAP_SIDE_DEF,
  parameter int unsigned CELL_BITS = CELL_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Request channel: taken when start is high and busy is low.
  input  wire logic       start,
  output logic            busy,
  input  grw_req_t        req_i,
  // Result channel: one strobe cycle per cast request.
  output logic            result_valid_o,
  output grw_rsp_t        result_o,
  // Configuration write port.
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [6:0] cfg_wdata_i
);

  grw_cmd_t cmd;
  grw_sts_t sts;

  // The controller sequences the divider, the shared multiplier and the
  // cell-by-cell walk; the datapath holds all arithmetic and the map.
  grw_ctrl #(
    .MAP_SIDE (MAP_SIDE)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .operation_i    (req_i.operation),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  grw_dpath #(
    .MAP_SIDE  (MAP_SIDE),
    .CELL_BITS (CELL_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
